// File: src/gwc_pkg.sv
// shared types, widths and register codes for the gravity wrench compensation block
package gwc_pkg;

    localparam int DATA_W    = 24;
    localparam int COM_W     = 20;
    localparam int QUAT_W    = 16;
    localparam int QUO_W     = 24;
    localparam int DEN_W     = 34;
    localparam int NUM_W     = DEN_W + QUO_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOOL_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COM_X       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COM_Y       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COM_Z       = 2'd3;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               orient_valid;
        logic signed [23:0] ext_force_x;
        logic signed [23:0] ext_force_y;
        logic signed [23:0] ext_force_z;
        logic signed [23:0] ext_torque_x;
        logic signed [23:0] ext_torque_y;
        logic signed [23:0] ext_torque_z;
    } item_t;

    typedef struct packed {
        logic signed [23:0] comp_force_x;
        logic signed [23:0] comp_force_y;
        logic signed [23:0] comp_force_z;
        logic signed [23:0] comp_torque_x;
        logic signed [23:0] comp_torque_y;
        logic signed [23:0] comp_torque_z;
        logic signed [23:0] grav_force_x;
        logic signed [23:0] grav_force_y;
        logic signed [23:0] grav_force_z;
        logic signed [23:0] grav_torque_x;
        logic signed [23:0] grav_torque_y;
        logic signed [23:0] grav_torque_z;
    } result_t;

endpackage

// File: src/gwc_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module gwc_div_pipe (
    input  logic                        clk,
    input  logic                        en,
    input  logic [gwc_pkg::NUM_W-1:0]   num,
    input  logic [gwc_pkg::DEN_W-1:0]   den,
    output logic [gwc_pkg::QUO_W-1:0]   quo
);
    import gwc_pkg::*;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_step
            logic [DEN_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [QUO_W-1:0] low_in;
            logic [QUO_W-1:0] quo_in;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             ge;
            logic [DEN_W-1:0] rem_next;

            if (k == 0)
            begin : g_first
                assign rem_in = num[NUM_W-1:QUO_W];
                assign low_in = num[QUO_W-1:0];
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign trial    = {rem_in, low_in[QUO_W-1]};
            assign diff     = trial - {1'b0, den_in};
            assign ge       = (trial >= {1'b0, den_in});
            assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= {low_in[QUO_W-2:0], 1'b0};
                    quo_reg[k] <= {quo_in[QUO_W-2:0], ge};
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W-1];

endmodule

// File: src/gravity_wrench_compensation_top.sv
// top level: gravity wrench compensation pipeline with config registers and output skid
//
// One item is taken every cycle while item_stall is low. The 24-stage divider normalises
// the rotated gravity force by the squared quaternion length, one quotient bit per stage,
// with three lanes for the three force components. A held result is kept in the output
// register and one more item is caught in a skid register, after which the input stalls
// until the output moves again. Configuration writes are taken every cycle and should be
// made only while no item is in flight.
module gravity_wrench_compensation_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  gwc_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output gwc_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gwc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gwc_pkg::DATA_W-1:0]       cfg_data
);
    import gwc_pkg::*;

    localparam int SQ_W       = 2 * QUAT_W;
    localparam int D_W        = DEN_W - 1;
    localparam int T_W        = DEN_W;
    localparam int ABS_W      = T_W - 1;
    localparam int MAG_W      = DATA_W + ABS_W;
    localparam int F_W        = QUO_W + 1;
    localparam int P_W        = COM_W + F_W;
    localparam int C_W        = P_W + 1;
    localparam int FRAC_SHIFT = 16;
    localparam int G_W        = C_W + 1 - FRAC_SHIFT;
    localparam int SAT_W      = 32;
    localparam int DIV_LAT    = QUO_W;

    localparam logic [C_W:0] ROUND_UP = (C_W+1)'(1) << (FRAC_SHIFT - 1);
    localparam logic [C_W:0] ROUND_DN = ROUND_UP - (C_W+1)'(1);
    localparam logic signed [SAT_W-1:0] OUT_MAX = (SAT_W)'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] OUT_MIN = -OUT_MAX - (SAT_W)'(1);

    typedef logic [5:0][DATA_W-1:0] wrench_t;

    typedef struct packed {
        logic       gv;
        logic [2:0] neg;
        wrench_t    ext;
    } side_t;

    function automatic logic [DATA_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        priority if (v > OUT_MAX)
            sat_out = OUT_MAX[DATA_W-1:0];
        else if (v < OUT_MIN)
            sat_out = OUT_MIN[DATA_W-1:0];
        else
            sat_out = v[DATA_W-1:0];
    endfunction

    // configuration registers
    logic [DATA_W-1:0]       tool_weight_reg;
    logic signed [COM_W-1:0] com_x_reg;
    logic signed [COM_W-1:0] com_y_reg;
    logic signed [COM_W-1:0] com_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tool_weight_reg <= 24'd8036;
            com_x_reg       <= 20'sd5734;
            com_y_reg       <= -20'sd4915;
            com_z_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TOOL_WEIGHT: tool_weight_reg <= cfg_data;
                CFG_COM_X:       com_x_reg       <= cfg_data[COM_W-1:0];
                CFG_COM_Y:       com_y_reg       <= cfg_data[COM_W-1:0];
                CFG_COM_Z:       com_z_reg       <= cfg_data[COM_W-1:0];
            endcase
        end
    end

    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign adv        = !skid_valid_reg;
    assign item_stall = skid_valid_reg;

    // stage 1: input register
    logic  s1_valid_reg;
    item_t s1_item_reg;
    wrench_t s1_ext;

    assign s1_ext = {s1_item_reg.ext_torque_z, s1_item_reg.ext_torque_y,
                     s1_item_reg.ext_torque_x, s1_item_reg.ext_force_z,
                     s1_item_reg.ext_force_y, s1_item_reg.ext_force_x};

    // stage 2: quaternion products
    logic                   s2_valid_reg;
    logic                   s2_orient_reg;
    wrench_t                s2_ext_reg;
    logic signed [SQ_W-1:0] s2_xx_reg, s2_yy_reg, s2_zz_reg, s2_ww_reg;
    logic signed [SQ_W-1:0] s2_xz_reg, s2_wy_reg, s2_yz_reg, s2_wx_reg;

    // stage 3: squared length and rotated gravity direction
    logic                  s3_valid_reg;
    logic                  s3_orient_reg;
    wrench_t               s3_ext_reg;
    logic [D_W-1:0]        s3_d_reg;
    logic signed [T_W-1:0] s3_t_reg [3];
    logic [D_W-1:0]        s3_d_next;
    logic signed [T_W-1:0] s3_t_next [3];
    logic signed [T_W-1:0] s3_xsum;
    logic signed [T_W-1:0] s3_ysum;

    assign s3_d_next = D_W'(s2_xx_reg[SQ_W-2:0]) + D_W'(s2_yy_reg[SQ_W-2:0])
                     + D_W'(s2_zz_reg[SQ_W-2:0]) + D_W'(s2_ww_reg[SQ_W-2:0]);
    assign s3_xsum      = T_W'(s2_xz_reg) + T_W'(s2_wy_reg);
    assign s3_ysum      = T_W'(s2_yz_reg) - T_W'(s2_wx_reg);
    assign s3_t_next[0] = {s3_xsum[T_W-2:0], 1'b0};
    assign s3_t_next[1] = {s3_ysum[T_W-2:0], 1'b0};
    assign s3_t_next[2] = T_W'(s2_ww_reg) + T_W'(s2_zz_reg) - T_W'(s2_xx_reg) - T_W'(s2_yy_reg);

    // stage 4: weight times magnitude
    logic             s4_valid_reg;
    side_t            s4_side_reg;
    logic [D_W-1:0]   s4_d_reg;
    logic [MAG_W-1:0] s4_mag_reg [3];
    logic [ABS_W-1:0] s4_abs [3];
    side_t            s4_side_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_side_next.neg[i] = s3_t_reg[i][T_W-1];
            s4_abs[i] = s3_t_reg[i][T_W-1] ? ABS_W'(-s3_t_reg[i]) : ABS_W'(s3_t_reg[i]);
        end
        s4_side_next.gv  = s3_orient_reg && (s3_d_reg != '0);
        s4_side_next.ext = s3_ext_reg;
    end

    // stage 5: rounded dividend and divisor
    logic             s5_valid_reg;
    side_t            s5_side_reg;
    logic [NUM_W-1:0] s5_num_reg [3];
    logic [DEN_W-1:0] s5_den_reg;

    // divider and its side line
    logic [DIV_LAT-1:0] dv_valid_reg;
    side_t              dv_side_reg [DIV_LAT];
    logic [QUO_W-1:0]   dv_quo [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            gwc_div_pipe u_div (
                .clk (clk),
                .en  (adv),
                .num (s5_num_reg[g]),
                .den (s5_den_reg),
                .quo (dv_quo[g])
            );
        end
    endgenerate

    // stage 6: signed gravity force
    logic                  s6_valid_reg;
    wrench_t               s6_ext_reg;
    logic signed [F_W-1:0] s6_f_reg [3];
    logic signed [F_W-1:0] s6_f_next [3];
    side_t                 dv_last;

    assign dv_last = dv_side_reg[DIV_LAT-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!dv_last.gv)
                s6_f_next[i] = '0;
            else if (dv_last.neg[i])
                s6_f_next[i] = F_W'({1'b0, dv_quo[i]});
            else
                s6_f_next[i] = -F_W'({1'b0, dv_quo[i]});
        end
    end

    // stage 7: torque products
    logic                  s7_valid_reg;
    wrench_t               s7_ext_reg;
    logic signed [F_W-1:0] s7_f_reg [3];
    logic signed [P_W-1:0] s7_p_reg [6];

    // stage 8: cross product differences
    logic                  s8_valid_reg;
    wrench_t               s8_ext_reg;
    logic signed [F_W-1:0] s8_f_reg [3];
    logic signed [C_W-1:0] s8_c_reg [3];

    // stage 9: torque rounded to 1/1024 n m
    logic                  s9_valid_reg;
    wrench_t               s9_ext_reg;
    logic signed [F_W-1:0] s9_f_reg [3];
    logic signed [G_W-1:0] s9_g_reg [3];
    logic [C_W:0]          s9_sum [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s9_sum[i] = (C_W+1)'(s8_c_reg[i]) + (s8_c_reg[i][C_W-1] ? ROUND_DN : ROUND_UP);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            dv_valid_reg <= {dv_valid_reg[DIV_LAT-2:0], s5_valid_reg};
            s6_valid_reg <= dv_valid_reg[DIV_LAT-1];
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= item;

            s2_orient_reg <= s1_item_reg.orient_valid;
            s2_ext_reg    <= s1_ext;
            s2_xx_reg     <= s1_item_reg.quat_x * s1_item_reg.quat_x;
            s2_yy_reg     <= s1_item_reg.quat_y * s1_item_reg.quat_y;
            s2_zz_reg     <= s1_item_reg.quat_z * s1_item_reg.quat_z;
            s2_ww_reg     <= s1_item_reg.quat_w * s1_item_reg.quat_w;
            s2_xz_reg     <= s1_item_reg.quat_x * s1_item_reg.quat_z;
            s2_wy_reg     <= s1_item_reg.quat_w * s1_item_reg.quat_y;
            s2_yz_reg     <= s1_item_reg.quat_y * s1_item_reg.quat_z;
            s2_wx_reg     <= s1_item_reg.quat_w * s1_item_reg.quat_x;

            s3_orient_reg <= s2_orient_reg;
            s3_ext_reg    <= s2_ext_reg;
            s3_d_reg      <= s3_d_next;

            s4_side_reg <= s4_side_next;
            s4_d_reg    <= s3_d_reg;

            s5_side_reg <= s4_side_reg;
            s5_den_reg  <= {s4_d_reg, 1'b0};

            dv_side_reg[0] <= s5_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
                dv_side_reg[k] <= dv_side_reg[k-1];

            s6_ext_reg <= dv_last.ext;

            s7_ext_reg  <= s6_ext_reg;
            s7_p_reg[0] <= com_y_reg * s6_f_reg[2];
            s7_p_reg[1] <= com_z_reg * s6_f_reg[1];
            s7_p_reg[2] <= com_z_reg * s6_f_reg[0];
            s7_p_reg[3] <= com_x_reg * s6_f_reg[2];
            s7_p_reg[4] <= com_x_reg * s6_f_reg[1];
            s7_p_reg[5] <= com_y_reg * s6_f_reg[0];

            s8_ext_reg <= s7_ext_reg;
            s9_ext_reg <= s8_ext_reg;

            for (int i = 0; i < 3; i++)
            begin
                s3_t_reg[i]   <= s3_t_next[i];
                s4_mag_reg[i] <= tool_weight_reg * s4_abs[i];
                s5_num_reg[i] <= {s4_mag_reg[i], 1'b0} + NUM_W'(s4_d_reg);
                s6_f_reg[i]   <= s6_f_next[i];
                s7_f_reg[i]   <= s6_f_reg[i];
                s8_f_reg[i]   <= s7_f_reg[i];
                s8_c_reg[i]   <= C_W'(s7_p_reg[2*i]) - C_W'(s7_p_reg[2*i+1]);
                s9_f_reg[i]   <= s8_f_reg[i];
                s9_g_reg[i]   <= s9_sum[i][C_W:FRAC_SHIFT];
            end
        end
    end

    // final stage: compensation and saturation
    result_t fin_data;
    logic    incoming;
    logic    take;
    result_t out_data_reg;
    result_t skid_data_reg;

    logic signed [SAT_W-1:0] fin_comp [6];
    logic signed [SAT_W-1:0] fin_grav [6];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fin_grav[i]   = SAT_W'(s9_f_reg[i]);
            fin_grav[i+3] = SAT_W'(s9_g_reg[i]);
        end
        for (int i = 0; i < 6; i++)
            fin_comp[i] = -SAT_W'($signed(s9_ext_reg[i])) - fin_grav[i];

        fin_data.comp_force_x  = sat_out(fin_comp[0]);
        fin_data.comp_force_y  = sat_out(fin_comp[1]);
        fin_data.comp_force_z  = sat_out(fin_comp[2]);
        fin_data.comp_torque_x = sat_out(fin_comp[3]);
        fin_data.comp_torque_y = sat_out(fin_comp[4]);
        fin_data.comp_torque_z = sat_out(fin_comp[5]);
        fin_data.grav_force_x  = sat_out(fin_grav[0]);
        fin_data.grav_force_y  = sat_out(fin_grav[1]);
        fin_data.grav_force_z  = sat_out(fin_grav[2]);
        fin_data.grav_torque_x = sat_out(fin_grav[3]);
        fin_data.grav_torque_y = sat_out(fin_grav[4]);
        fin_data.grav_torque_z = sat_out(fin_grav[5]);
    end

    assign incoming = adv && s9_valid_reg;
    assign take     = out_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
            out_valid_reg <= incoming;
        else if (incoming)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || take)
            out_data_reg <= fin_data;
        else if (incoming)
            skid_data_reg <= fin_data;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && result_stall))
        else $error("skid filled while output was free");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction with an empty output register");

    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[DIV_LAT-1] && dv_last.gv) |->
            ((dv_quo[0] <= tool_weight_reg) && (dv_quo[1] <= tool_weight_reg)
             && (dv_quo[2] <= tool_weight_reg)))
        else $error("gravity force quotient exceeds tool weight");

endmodule
